// ===== hw/rtl/fdl_pkg.sv =====
package fdl_pkg;

    // Default sizes of the sample store and the sample format
    localparam int MAX_DEPTH_DEF   = 4096;
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int FRAC_BITS_DEF   = 8;

    // Fixed field widths
    localparam int DELAY_W   = 20;
    localparam int LEN_REG_W = 13;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINE_LENGTH = 1'b0,
        CFG_INTERP_MODE = 1'b1
    } cfg_index_t;

endpackage

// ===== hw/rtl/fractional_delay_line_top.sv =====
// Pipeline: the sample memory is read into the read registers at the accepting
// edge, then the output register and out_valid are loaded when that stage may
// advance (output register empty or out_ready high).
// Throughput: one sample per cycle while out_ready keeps the output moving, set by
// the sample memory's two read ports and one write port, all used in the accept cycle.
// Reset: rst_n clears control state at once; a clearing pass then zeroes every
// sample memory address in turn, with in_ready low (config writes still taken).
module fractional_delay_line_top #(
    parameter int MAX_DEPTH   = fdl_pkg::MAX_DEPTH_DEF,
    parameter int SAMPLE_BITS = fdl_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = fdl_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [fdl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fdl_pkg::LEN_REG_W-1:0] cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] audio_in,
    input  logic [fdl_pkg::DELAY_W-1:0]   delay_amount,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] audio_out
);
    import fdl_pkg::*;

    localparam int ADDR_W = $clog2(MAX_DEPTH);
    localparam int LEN_W  = $clog2(MAX_DEPTH + 1);
    localparam int CW     = ((DELAY_W > LEN_W + FRAC_BITS) ? DELAY_W : LEN_W + FRAC_BITS) + 1;
    localparam int PW     = SAMPLE_BITS + FRAC_BITS + 2;

    // Sample memory
    logic [SAMPLE_BITS-1:0] mem [MAX_DEPTH];

    // Control registers
    logic                 clear_active_reg, clear_active_next;
    logic [ADDR_W-1:0]    clear_cnt_reg, clear_cnt_next;
    logic [ADDR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [LEN_REG_W-1:0] line_length_reg, line_length_next;
    logic                 mode_reg, mode_next;
    logic                 s1_valid_reg, s1_valid_next;
    logic                 out_valid_reg, out_valid_next;

    // Payload registers
    logic [SAMPLE_BITS-1:0] rd_a_reg, rd_b_reg;
    logic [FRAC_BITS-1:0]   frac_reg;
    logic                   interp_reg;
    logic [SAMPLE_BITS-1:0] audio_out_reg, audio_out_next;

    // Request datapath
    logic                   accept;
    logic                   s1_adv;
    logic [31:0]            len32;
    logic [LEN_W-1:0]       len_eff;
    logic [ADDR_W-1:0]      ptr;
    logic                   interp;
    logic [CW-1:0]          dly, dly_lo, dly_hi;
    logic [LEN_W-1:0]       lower;
    logic [FRAC_BITS-1:0]   frac;
    logic [LEN_W:0]         t1_raw, t1, t2_raw, t2, len_x;
    logic [LEN_W-1:0]       ptr_inc;
    logic [ADDR_W-1:0]      addr_a, addr_b;
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    logic [SAMPLE_BITS-1:0] mem_wdata;

    // Interpolation
    logic signed [SAMPLE_BITS-1:0] first_s, second_s;
    logic signed [SAMPLE_BITS:0]   diff;
    logic signed [FRAC_BITS:0]     frac_s;
    logic signed [PW-1:0]          prod, sum;
    logic [SAMPLE_BITS-1:0]        interp_res;

    // Handshake
    always_comb
    begin
        s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
        in_ready = !clear_active_reg && (!s1_valid_reg || s1_adv);
        accept   = in_valid && in_ready;
    end

    // Effective length, pointer and read addresses
    always_comb
    begin
        len32 = 32'(line_length_reg);
        if (len32 == 32'd0)
        begin
            len32 = 32'd1;
        end
        if (len32 > 32'(MAX_DEPTH))
        begin
            len32 = 32'(MAX_DEPTH);
        end
        len_eff = LEN_W'(len32);
        ptr     = (LEN_W'(wr_ptr_reg) < len_eff) ? wr_ptr_reg : '0;
        interp  = mode_reg && (len_eff >= LEN_W'(2));

        // clamp delay to one through length minus one samples
        dly    = CW'(delay_amount);
        dly_lo = CW'(1) << FRAC_BITS;
        dly_hi = CW'(len_eff - LEN_W'(1)) << FRAC_BITS;
        if (dly < dly_lo)
        begin
            dly = dly_lo;
        end
        if (dly > dly_hi)
        begin
            dly = dly_hi;
        end
        lower = dly[FRAC_BITS +: LEN_W];
        frac  = dly[FRAC_BITS-1:0];

        // wrap ptr - lower and ptr - lower - 1 into the line
        len_x  = (LEN_W+1)'(len_eff);
        t1_raw = (LEN_W+1)'(ptr) + len_x - (LEN_W+1)'(lower);
        t2_raw = t1_raw - (LEN_W+1)'(1);
        t1     = (t1_raw >= len_x) ? t1_raw - len_x : t1_raw;
        t2     = (t2_raw >= len_x) ? t2_raw - len_x : t2_raw;
        addr_a = interp ? ADDR_W'(t1) : ptr;
        addr_b = ADDR_W'(t2);

        ptr_inc = LEN_W'(ptr) + LEN_W'(1);
    end

    // Memory write port: clearing pass or incoming sample
    always_comb
    begin
        if (clear_active_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clear_cnt_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = accept;
            mem_waddr = ptr;
            mem_wdata = audio_in;
        end
    end

    // Sample memory, read-before-write
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (accept)
        begin
            rd_a_reg <= mem[addr_a];
            rd_b_reg <= mem[addr_b];
        end
    end

    // Hold request attributes alongside the read data; load the output register on advance
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            frac_reg   <= frac;
            interp_reg <= interp;
        end
        if (s1_adv)
        begin
            audio_out_reg <= audio_out_next;
        end
    end

    // Interpolate: first + (second - first) * f, round half up
    always_comb
    begin
        first_s    = signed'(rd_a_reg);
        second_s   = signed'(rd_b_reg);
        diff       = (SAMPLE_BITS+1)'(second_s) - (SAMPLE_BITS+1)'(first_s);
        frac_s     = signed'({1'b0, frac_reg});
        prod       = PW'(diff) * PW'(frac_s);
        sum        = (PW'(first_s) <<< FRAC_BITS) + prod + (PW'(1) <<< (FRAC_BITS - 1));
        interp_res = SAMPLE_BITS'(sum >>> FRAC_BITS);
        audio_out_next = interp_reg ? interp_res : rd_a_reg;
    end

    // Next state of control registers
    always_comb
    begin
        clear_active_next = clear_active_reg;
        clear_cnt_next    = clear_cnt_reg;
        wr_ptr_next       = wr_ptr_reg;
        line_length_next  = line_length_reg;
        mode_next         = mode_reg;
        s1_valid_next     = s1_valid_reg;
        out_valid_next    = out_valid_reg;

        // advance the clearing pass
        if (clear_active_reg)
        begin
            if (clear_cnt_reg == ADDR_W'(MAX_DEPTH - 1))
            begin
                clear_active_next = 1'b0;
            end
            else
            begin
                clear_cnt_next = clear_cnt_reg + ADDR_W'(1);
            end
        end

        // advance the write pointer
        if (accept)
        begin
            wr_ptr_next = (ptr_inc >= len_eff) ? '0 : ADDR_W'(ptr_inc);
        end

        // configuration writes
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LINE_LENGTH: line_length_next = cfg_data;
                CFG_INTERP_MODE: mode_next        = cfg_data[0];
                default:         ;
            endcase
        end

        // pipeline valid flags
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_active_reg <= 1'b1;
            clear_cnt_reg    <= '0;
            wr_ptr_reg       <= '0;
            line_length_reg  <= LEN_REG_W'(1);
            mode_reg         <= 1'b0;
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            clear_active_reg <= clear_active_next;
            clear_cnt_reg    <= clear_cnt_next;
            wr_ptr_reg       <= wr_ptr_next;
            line_length_reg  <= line_length_next;
            mode_reg         <= mode_next;
            s1_valid_reg     <= s1_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign audio_out = signed'(audio_out_reg);

endmodule

// ===== dv/fdl_checker.sv =====
module fdl_checker #(
    parameter int MAX_DEPTH   = fdl_pkg::MAX_DEPTH_DEF,
    parameter int SAMPLE_BITS = fdl_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = fdl_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [fdl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fdl_pkg::LEN_REG_W-1:0] cfg_data,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] audio_in,
    input  logic [fdl_pkg::DELAY_W-1:0]   delay_amount,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic signed [SAMPLE_BITS-1:0] audio_out,
    output int                            error_count,
    output int                            pending_count,
    output int                            checked_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import fdl_pkg::*;

    localparam int MAX_REPORTS = 10;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    // Shadow of the delay line and its registers
    sample_t              line_mem [MAX_DEPTH];
    int                   wr_ptr;
    logic [LEN_REG_W-1:0] len_reg;
    logic                 mode_reg;

    // Samples still owed by the block, oldest first
    sample_t              owed_samples [$];
    int                   errs;
    int                   checked;
    sample_t              owed;

    // Produce the delayed sample for one request, then store the new sample
    function automatic sample_t delay_line_step(input sample_t smp,
                                                input logic [DELAY_W-1:0] dly);
        int      len;
        int      p;
        int      lower;
        longint  d;
        longint  frac;
        longint  one;
        longint  first;
        longint  second;
        longint  acc;
        sample_t result;
        one = longint'(1) << FRAC_BITS;
        len = (len_reg == 0) ? 1 : ((len_reg > MAX_DEPTH) ? MAX_DEPTH : int'(len_reg));
        p = (wr_ptr < len) ? wr_ptr : 0;
        if (mode_reg && len >= 2)
        begin
            // Clamp the delay to one sample up to length minus one
            d = longint'(dly);
            if (d < one)
                d = one;
            if (d > (longint'(len - 1) << FRAC_BITS))
                d = longint'(len - 1) << FRAC_BITS;
            lower = int'(d >> FRAC_BITS);
            frac = d & (one - 1);
            first = line_mem[(p + len - lower) % len];
            second = line_mem[(p + len - lower - 1) % len];
            // Weighted sum, round half up, floor by arithmetic shift
            acc = first * (one - frac) + second * frac + (one >>> 1);
            result = sample_t'(acc >>> FRAC_BITS);
        end
        else
        begin
            result = line_mem[p];
        end
        line_mem[p] = smp;
        wr_ptr = (p + 1 >= len) ? 0 : p + 1;
        return result;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_DEPTH; i++)
                line_mem[i] = '0;
            wr_ptr = 0;
            len_reg = 1;
            mode_reg = 1'b0;
            owed_samples.delete();
            pending_count <= 0;
        end
        else
        begin
            // Track register writes
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_LINE_LENGTH: len_reg = cfg_data;
                    CFG_INTERP_MODE: mode_reg = cfg_data[0];
                    default: ;
                endcase
            end

            // Compare each accepted output request with the oldest owed sample
            if (out_valid && out_ready)
            begin
                if (owed_samples.size() == 0)
                begin
                    errs++;
                    if (errs <= MAX_REPORTS)
                        $display("[%0t] unexpected audio_out %0d with nothing owed",
                                 $realtime, audio_out);
                end
                else
                begin
                    owed = owed_samples.pop_front();
                    checked++;
                    if (audio_out !== owed)
                    begin
                        errs++;
                        if (errs <= MAX_REPORTS)
                            $display("[%0t] audio_out mismatch on sample %0d: expected %0d (%06h), got %0d (%06h)",
                                     $realtime, checked, owed, owed, audio_out, audio_out);
                    end
                end
            end

            // Predict on each accepted input request
            if (in_valid && in_ready)
                owed_samples.push_back(delay_line_step(audio_in, delay_amount));

            pending_count <= owed_samples.size();
            error_count <= errs;
            checked_count <= checked;
        end
    end

endmodule

// ===== dv/tb_fractional_delay_line_top.sv =====
module tb_fractional_delay_line_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fdl_pkg::*;

    localparam int SAMPLE_BITS    = SAMPLE_BITS_DEF;
    localparam int MAX_DEPTH      = MAX_DEPTH_DEF;
    localparam int RANDOM_ITEMS   = 1700;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_TAIL     = 6;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [DELAY_W-1:0]            delay_t;

    localparam sample_t SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam sample_t SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam delay_t  DLY_MAX = '1;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [LEN_REG_W-1:0] cfg_data     = '0;
    logic                 in_valid     = 1'b0;
    logic                 in_ready;
    sample_t              audio_in     = '0;
    delay_t               delay_amount = '0;
    logic                 out_valid;
    logic                 out_ready    = 1'b0;
    sample_t              audio_out;

    int fail_count;
    int pending_count;
    int checked_count;

    // Stimulus bookkeeping
    int     s_idle_pct;
    int     r_idle_pct;
    bit     stall_request;
    int     sent;
    int     settings;
    int     cur_len;
    int     seg_items;
    int     upper;
    int     idle_cycles = 0;
    bit     held_early;
    bit     held_late;
    logic [LEN_REG_W-1:0] pick_len;
    logic   pick_mode;
    sample_t smp;
    delay_t  dly;

    fractional_delay_line_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .audio_in     (audio_in),
        .delay_amount (delay_amount),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .audio_out    (audio_out)
    );

    fdl_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .audio_in      (audio_in),
        .delay_amount  (delay_amount),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .audio_out     (audio_out),
        .error_count   (fail_count),
        .pending_count (pending_count),
        .checked_count (checked_count)
    );

    // Free-running clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Drive out_ready: random idling, or a long hold when requested
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (stall_request)
            begin
                stall_request = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            out_ready <= ($urandom_range(99) >= r_idle_pct);
        end
    end

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no request accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("tb_fractional_delay_line_top NOT OK");
            $finish;
        end
    end

    // Offer one input request and hold it until accepted
    task automatic send_sample(input sample_t s, input delay_t d);
        while ($urandom_range(99) < s_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        audio_in <= s;
        delay_amount <= d;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent++;
    endtask

    // Stop offering and wait for every owed sample to come back
    task automatic drain_line();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [LEN_REG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Drain, then set length and mode
    task automatic configure(input logic [LEN_REG_W-1:0] len, input logic mode);
        drain_line();
        write_reg(CFG_LINE_LENGTH, len);
        write_reg(CFG_INTERP_MODE, {{(LEN_REG_W-1){1'b0}}, mode});
        cur_len = (len == 0) ? 1 : ((len > MAX_DEPTH) ? MAX_DEPTH : int'(len));
        settings++;
    endtask

    initial
    begin
        sent = 0;
        settings = 0;
        cur_len = 1;
        stall_request = 1'b0;
        held_early = 1'b0;
        held_late = 1'b0;
        s_idle_pct = 26;
        r_idle_pct = 53;

        // Hold reset, then release; the block clears its store afterwards
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults: length one, fixed delay
        send_sample(SMP_MAX, '0);
        send_sample(SMP_MIN, DLY_MAX);
        send_sample('0, '0);

        // Interpolation: both delay clamps, mid fractions, extremes for rounding
        configure(LEN_REG_W'(4), 1'b1);
        send_sample(SMP_MAX, '0);
        send_sample(SMP_MIN, DLY_MAX);
        send_sample(sample_t'(1), 20'h00180);
        send_sample(sample_t'(-1), 20'h001FF);
        send_sample(sample_t'(-3), 20'h00280);
        send_sample(SMP_MIN, 20'h00101);
        send_sample(SMP_MAX, 20'h00180);
        send_sample(sample_t'(-2), 20'h002FF);

        // Zero length acts as one; interpolation with one sample is a plain delay
        configure(LEN_REG_W'(0), 1'b1);
        send_sample(sample_t'(12345), 20'h00180);
        send_sample(SMP_MIN, DLY_MAX);
        send_sample(sample_t'(-7), 20'h00000);

        // Oversized length is capped at the store depth
        configure('1, 1'b0);
        send_sample(sample_t'(11), '0);
        send_sample(sample_t'(-22), '0);
        send_sample(SMP_MAX, '0);
        send_sample(SMP_MIN, '0);
        send_sample(sample_t'(55), '0);

        // Shrink the line below the write pointer
        configure(LEN_REG_W'(3), 1'b1);
        send_sample(sample_t'(-100), 20'h00180);
        send_sample(sample_t'(200), 20'h00080);
        send_sample(sample_t'(-300), 20'h00200);
        send_sample(SMP_MAX, 20'h001FF);
        send_sample(SMP_MIN, 20'h00140);

        // Random segments, each with its own register setting
        while (sent < RANDOM_ITEMS + 25)
        begin
            if (sent < 600)
            begin
                s_idle_pct = 26;
                r_idle_pct = 53;
            end
            else if (sent < 1150)
            begin
                s_idle_pct = 53;
                r_idle_pct = 26;
            end
            else
            begin
                s_idle_pct = 0;
                r_idle_pct = 0;
            end

            case ($urandom_range(11))
                0: pick_len = LEN_REG_W'(1);
                1: pick_len = LEN_REG_W'(2);
                2: pick_len = LEN_REG_W'(3);
                3: pick_len = LEN_REG_W'(MAX_DEPTH);
                4: pick_len = LEN_REG_W'(0);
                5: pick_len = LEN_REG_W'($urandom_range(MAX_DEPTH + 1, (1 << LEN_REG_W) - 1));
                6: pick_len = LEN_REG_W'($urandom_range(1, MAX_DEPTH));
                default: pick_len = LEN_REG_W'($urandom_range(2, 64));
            endcase
            pick_mode = ($urandom_range(2) != 0);
            configure(pick_len, pick_mode);

            seg_items = $urandom_range(20, 80);

            // Long output hold while input keeps coming, once early and once late
            if (!held_early && sent >= 150)
            begin
                held_early = 1'b1;
                stall_request = 1'b1;
                seg_items = 80;
            end
            else if (!held_late && sent >= 1150)
            begin
                held_late = 1'b1;
                stall_request = 1'b1;
                seg_items = 80;
            end

            repeat (seg_items)
            begin
                case ($urandom_range(9))
                    0: smp = SMP_MAX;
                    1: smp = SMP_MIN;
                    2: smp = sample_t'($urandom_range(2)) - sample_t'(1);
                    default: smp = sample_t'($urandom);
                endcase
                upper = cur_len * 256 + 255;
                if (upper > int'(DLY_MAX))
                    upper = int'(DLY_MAX);
                if ($urandom_range(3) == 0)
                    dly = delay_t'($urandom);
                else
                    dly = delay_t'($urandom_range(0, upper));
                send_sample(smp, dly);
            end
        end

        // Let everything come back before reporting
        drain_line();

        $display("Checked %0d samples over %0d register settings,", checked_count, settings);
        $display("lengths 0 to 8191 in both modes, with idling on both sides,");
        $display("long output holds and the post-reset clear.");
        if (fail_count == 0)
            $display("tb_fractional_delay_line_top OK");
        else
            $display("tb_fractional_delay_line_top NOT OK");
        $finish;
    end

endmodule
